// ===== rtl/tdfm_pkg.sv =====
package tdfm_pkg;

  localparam int STORE_TILES = 256;
  localparam int SLOT_W = $clog2(STORE_TILES);
  localparam int CNT_W = $clog2(STORE_TILES + 1);
  localparam int MAP_POSITIONS = 8192;
  localparam int ADDR_W = SLOT_W + 3;

  localparam logic [1:0] CFG_KEEP_ALL = 2'd0;
  localparam logic [1:0] CFG_BLOCK = 2'd1;
  localparam logic [1:0] CFG_BASE = 2'd2;

  localparam logic [15:0] FLAG_H = 16'h0800;
  localparam logic [15:0] FLAG_V = 16'h1000;
  localparam logic [15:0] FLAG_PRIO = 16'h8000;
  localparam logic [11:0] MAX_NUMBER = 12'h7FF;
  localparam logic [12:0] PRIO_START = 13'(23 * 16);
  localparam logic [3:0] PAD_COL = 4'hC;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NUMBER = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_MAP = 1'b1;

  typedef struct packed {
    logic        op;
    logic [12:0] tile_position;
    logic [2:0]  row_index;
    logic [31:0] row_pixels;
  } in_item_t;

  typedef struct packed {
    logic [15:0] map_word;
    logic [8:0]  tiles_stored;
    logic [1:0]  status;
  } out_item_t;

  // Job handed from front to back: one completed tile plus its context.
  typedef struct packed {
    logic        op;
    logic        start;
    logic [12:0] pos;
    logic [7:0][31:0] rows;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_CLEAR, BK_CMP, BK_STORE, BK_DONE
  } bk_state_t;

  function automatic logic [31:0] mirror_row(input logic [31:0] x);
    logic [31:0] r;
    for (int k = 0; k < 8; k++) r[4*k +: 4] = x[28 - 4*k +: 4];
    return r;
  endfunction

endpackage

// ===== rtl/tdfm_front.sv =====
module tdfm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  tdfm_pkg::in_item_t in_data,
  output logic               job_valid,
  input  logic               job_ready,
  output tdfm_pkg::job_t     job
);

  logic [7:0][31:0] rows_r;
  logic             start_r;
  logic             job_valid_r;
  tdfm_pkg::job_t   job_r;
  logic             take;
  logic             in_range;

  assign in_full = job_valid_r;
  assign take = in_push && !job_valid_r;
  assign in_range = 32'(in_data.tile_position) < 32'(tdfm_pkg::MAP_POSITIONS);
  assign job_valid = job_valid_r;
  assign job = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      start_r <= 1'b0;
    end else begin
      if (job_valid_r && job_ready) job_valid_r <= 1'b0;
      if (take && in_range) begin
        if (in_data.row_index == 3'd7) begin
          job_valid_r <= 1'b1;
          start_r <= 1'b0;
        end else if (in_data.op == tdfm_pkg::OP_BUILD && in_data.tile_position == 13'd0
                     && in_data.row_index == 3'd0) begin
          start_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_range) begin
      rows_r[in_data.row_index] <= in_data.row_pixels;
      if (in_data.row_index == 3'd7) begin
        job_r.op <= in_data.op;
        job_r.pos <= in_data.tile_position;
        job_r.start <= start_r;
        job_r.rows <= {in_data.row_pixels, rows_r[6:0]};
      end
    end
  end

endmodule

// ===== rtl/tdfm_back.sv =====
module tdfm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 keep_all,
  input  logic                 block_layout,
  input  logic [10:0]          base_tile,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  tdfm_pkg::job_t       job,
  output logic                 out_empty,
  input  logic                 out_pop,
  output tdfm_pkg::out_item_t  out_data
);

  localparam int AW = tdfm_pkg::ADDR_W;
  localparam int CW = tdfm_pkg::CNT_W;

  typedef tdfm_pkg::out_item_t out_item_t_l;

  logic [31:0] mem [2**AW];
  logic [31:0] rd_r;

  tdfm_pkg::bk_state_t state_r, state_nxt;
  tdfm_pkg::job_t      job_r;
  logic [CW-1:0]       count_r;
  logic [1:0]          err_r;
  logic [tdfm_pkg::SLOT_W-1:0] slot_r;
  logic [1:0]          orient_r;
  logic [3:0]          step_r;
  logic                eq_r;
  logic                full_r;
  logic [15:0]         word_r;
  out_item_t_l         res_r;

  logic [AW-1:0] raddr, waddr;
  logic [31:0]   wdata, want;
  logic          we;
  logic [2:0]    rsel;
  logic          last_slot;
  logic          hit;
  logic [11:0]   number;
  logic          pad;
  logic          need_search;
  logic          clearing;
  logic          res_load;

  // A new job may start while the previous result still waits in res_r.
  assign job_ready = (state_r == tdfm_pkg::BK_IDLE);
  assign out_empty = !full_r;
  assign out_data = res_r;

  // Read address runs one step ahead of the compare of the previous row.
  assign raddr = {slot_r, step_r[2:0]};
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  assign rsel = orient_r[1] ? 3'(7 - 32'(step_r[2:0] - 3'd1)) : 3'(step_r[2:0] - 3'd1);
  assign want = orient_r[0] ? tdfm_pkg::mirror_row(job_r.rows[rsel]) : job_r.rows[rsel];
  assign last_slot = 32'(slot_r) + 1 >= 32'(count_r);
  assign hit = (step_r == 4'd8) && eq_r && (rd_r == want);
  assign number = 12'(slot_r) + 12'(base_tile);
  assign pad = block_layout && (job_r.pos[1:0] == 2'd3 || job_r.pos[3:0] >= tdfm_pkg::PAD_COL);
  assign need_search = !(job_r.op == tdfm_pkg::OP_BUILD && keep_all);
  assign clearing = job_r.start && err_r == tdfm_pkg::ST_OK && !keep_all;
  assign res_load = (state_r == tdfm_pkg::BK_DONE) && (!full_r || out_pop);

  always_comb begin
    we = 1'b0;
    waddr = {slot_r, step_r[2:0]};
    wdata = job_r.rows[step_r[2:0]];
    if (state_r == tdfm_pkg::BK_CLEAR) begin
      we = clearing;
      wdata = '0;
    end else if (state_r == tdfm_pkg::BK_STORE) begin
      we = count_r < CW'(tdfm_pkg::STORE_TILES);
      waddr = {count_r[tdfm_pkg::SLOT_W-1:0], step_r[2:0]};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tdfm_pkg::BK_IDLE: if (job_valid && job_ready) state_nxt = tdfm_pkg::BK_CLEAR;
      tdfm_pkg::BK_CLEAR: begin
        if (!clearing || step_r == 4'd7) begin
          if (err_r != tdfm_pkg::ST_OK) state_nxt = tdfm_pkg::BK_DONE;
          else if (job_r.op == tdfm_pkg::OP_MAP && pad) state_nxt = tdfm_pkg::BK_DONE;
          else if (!need_search) state_nxt = tdfm_pkg::BK_STORE;
          else state_nxt = tdfm_pkg::BK_CMP;
        end
      end
      tdfm_pkg::BK_CMP: begin
        if (count_r == '0)
          state_nxt = (job_r.op == tdfm_pkg::OP_BUILD) ? tdfm_pkg::BK_STORE
                                                      : tdfm_pkg::BK_DONE;
        else if (step_r == 4'd8) begin
          if (hit) state_nxt = tdfm_pkg::BK_DONE;
          else if (last_slot && orient_r == 2'd3)
            state_nxt = (job_r.op == tdfm_pkg::OP_BUILD) ? tdfm_pkg::BK_STORE
                                                        : tdfm_pkg::BK_DONE;
        end
      end
      tdfm_pkg::BK_STORE: begin
        if (count_r >= CW'(tdfm_pkg::STORE_TILES) || step_r == 4'd7)
          state_nxt = tdfm_pkg::BK_DONE;
      end
      tdfm_pkg::BK_DONE: if (res_load) state_nxt = tdfm_pkg::BK_IDLE;
      default: state_nxt = tdfm_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdfm_pkg::BK_IDLE;
      count_r <= '0;
      err_r <= tdfm_pkg::ST_OK;
      full_r <= 1'b0;
      step_r <= '0;
      slot_r <= '0;
      orient_r <= '0;
      eq_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) full_r <= 1'b1;
      else if (full_r && out_pop) full_r <= 1'b0;
      unique case (state_r)
        tdfm_pkg::BK_IDLE: begin
          step_r <= '0;
          slot_r <= '0;
          orient_r <= '0;
          eq_r <= 1'b1;
          word_r <= '0;
        end
        tdfm_pkg::BK_CLEAR: begin
          if (state_nxt != tdfm_pkg::BK_CLEAR) begin
            step_r <= '0;
            eq_r <= 1'b1;
            if (job_r.start && err_r == tdfm_pkg::ST_OK)
              count_r <= keep_all ? CW'(0) : CW'(1);
          end else step_r <= step_r + 4'd1;
        end
        tdfm_pkg::BK_CMP: begin
          if (count_r == '0) begin
            step_r <= '0;
            if (job_r.op == tdfm_pkg::OP_MAP) err_r <= tdfm_pkg::ST_NOMATCH;
          end else if (step_r == 4'd8) begin
            step_r <= '0;
            eq_r <= 1'b1;
            if (!hit) begin
              if (last_slot) begin
                slot_r <= '0;
                orient_r <= orient_r + 2'd1;
              end else slot_r <= slot_r + 1'b1;
              if (last_slot && orient_r == 2'd3 && job_r.op == tdfm_pkg::OP_MAP)
                err_r <= tdfm_pkg::ST_NOMATCH;
            end else if (job_r.op == tdfm_pkg::OP_MAP) begin
              if (number > tdfm_pkg::MAX_NUMBER) err_r <= tdfm_pkg::ST_NUMBER;
              else word_r <= (block_layout && job_r.pos >= tdfm_pkg::PRIO_START
                              ? tdfm_pkg::FLAG_PRIO : 16'h0)
                             | (orient_r[0] ? tdfm_pkg::FLAG_H : 16'h0)
                             | (orient_r[1] ? tdfm_pkg::FLAG_V : 16'h0)
                             | {5'd0, number[10:0]};
            end
          end else begin
            step_r <= step_r + 4'd1;
            if (step_r != 4'd0 && rd_r != want) eq_r <= 1'b0;
          end
        end
        tdfm_pkg::BK_STORE: begin
          step_r <= step_r + 4'd1;
          if (count_r >= CW'(tdfm_pkg::STORE_TILES)) err_r <= tdfm_pkg::ST_FULL;
          else if (step_r == 4'd7) count_r <= count_r + 1'b1;
        end
        tdfm_pkg::BK_DONE: begin
          if (res_load) begin
            res_r.map_word <= (err_r != tdfm_pkg::ST_OK) ? 16'h0 : word_r;
            res_r.tiles_stored <= 9'(count_r);
            res_r.status <= err_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tdfm_pkg::BK_IDLE && job_valid && job_ready) job_r <= job;
  end

endmodule

// ===== rtl/tile_dedup_flip_matcher.sv =====
// Channel   Handshake        Payload
// in        in_push/in_full  tdfm_pkg::in_item_t
// out       out_pop/out_empty tdfm_pkg::out_item_t
// cfg       cfg_we           cfg_index, cfg_data
// A row item is taken while the hand-off register is free; the row that
// completes a tile goes to the back end, which searches the tile store one
// row per cycle over one memory port, through each stored tile in all four
// orientations. Storing a tile or clearing the blank tile writes its 8 rows.
// Reset is synchronous and active low; the store holds no valid bits.
// The front stalls while the hand-off register is occupied; the back end
// holds its finished result while the previous one is still unread.
module tile_dedup_flip_matcher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  tdfm_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output tdfm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [10:0]         cfg_data
);

  logic           keep_all_r;
  logic           block_r;
  logic [10:0]    base_r;
  logic           job_valid;
  logic           job_ready;
  tdfm_pkg::job_t job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_all_r <= 1'b0;
      block_r <= 1'b0;
      base_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == tdfm_pkg::CFG_KEEP_ALL) keep_all_r <= cfg_data[0];
      if (cfg_index == tdfm_pkg::CFG_BLOCK) block_r <= cfg_data[0];
      if (cfg_index == tdfm_pkg::CFG_BASE) base_r <= cfg_data;
    end
  end

  tdfm_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .job_valid, .job_ready, .job
  );

  tdfm_back u_back (
    .clk, .rst_n, .keep_all(keep_all_r), .block_layout(block_r), .base_tile(base_r),
    .job_valid, .job_ready, .job, .out_empty, .out_pop, .out_data
  );

`ifndef ASSERT_OFF
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_data.tiles_stored <= 9'(tdfm_pkg::STORE_TILES) || out_empty)
    else $error("stored count beyond capacity");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status != tdfm_pkg::ST_OK) |-> out_data.map_word == 16'h0)
    else $error("error result with nonzero word");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_data))
    else $error("result changed while waiting");
`endif

endmodule
